@@ hw/rtl/afc_pkg.sv @@
package afc_pkg;

   localparam int MAX_W = 256;
   localparam int MAX_H = 256;
   localparam int CELLS = MAX_W * MAX_H;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int DIM_W = $clog2(MAX_W) + 1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] OPAQUE_ALPHA = 8'hFF;
   localparam logic [15:0] DELAY_MAX = 16'hFFFF;
   localparam logic [31:0] BACKGROUND = 32'h0000_0000;

   localparam logic [0:0] REG_WIDTH = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PIXEL  = 2'd1,
      KIND_FINAL  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      DISP_LEAVE   = 2'd0,
      DISP_CLEAR   = 2'd1,
      DISP_RESTORE = 2'd2
   } disp_type;

   typedef enum logic [1:0] {
      ALPHA_CLEAR   = 2'd0,
      ALPHA_OPAQUE  = 2'd1,
      ALPHA_PARTIAL = 2'd2
   } alpha_type;

   typedef enum logic [1:0] {
      STAT_ACCEPTED  = 2'd0,
      STAT_COMPLETED = 2'd1,
      STAT_READ      = 2'd2,
      STAT_ERROR     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_PARTIAL   = 2'd1,
      ERR_NO_FRAMES = 2'd2
   } err_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_DISPOSE,
      S_COMMIT,
      S_SAVE
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] frame_x;
      logic signed [15:0] frame_y;
      logic [11:0]        frame_width;
      logic [11:0]        frame_height;
      disp_type           disposal;
      logic [15:0]        frame_delay;
      logic               empty;
      logic [31:0]        pixel_rgba;
      alpha_type          alpha;
      logic [15:0]        read_index;
   } cmd_type;

   typedef struct packed {
      status_type  status;
      err_type     error_code;
      logic [15:0] completed_delay;
      logic        is_final;
      logic [31:0] read_pixel;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic              to_canvas;
      logic [ADDR_W-1:0] caddr;
      logic [ADDR_W-1:0] saddr;
   } wb_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [8:0] v,
                                                  input logic [DIM_W-1:0] top);
      logic [DIM_W-1:0] r;
      if (v == 9'd0) begin
         r = DIM_W'(1);
      end else if ({{(DIM_W > 9 ? DIM_W - 9 : 0){1'b0}}, v} > top) begin
         r = top;
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [DIM_W-1:0] clip_pos(input logic signed [17:0] v,
                                                 input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({{(18 - DIM_W){1'b0}}, hi})) begin
         r = hi;
      end else begin
         r = v[DIM_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/afc_ram.sv @@
module afc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ hw/rtl/afc_queue.sv @@
module afc_queue import afc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head
);

   cmd_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in;
   logic [QPTR_W-1:0]  rd_ff, rd_in;
   logic [QPTR_W:0]    count_ff, count_in;

   assign full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head = slot_ff[rd_ff];

   always_comb begin
      wr_in = push ? QPTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in = pop ? QPTR_W'(rd_ff + 1'b1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/afc_front.sv @@
module afc_front import afc_pkg::*; (
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         clearing,
   input  logic         queue_full,
   output logic         push,
   output cmd_type      cmd
);

   logic [7:0] alpha;

   assign req_tready = !queue_full && !clearing;
   assign push = req_tvalid && req_tready;
   assign alpha = req_tdata[106:99];

   always_comb begin
      cmd.kind = kind_type'(req_tuser);
      cmd.frame_x = $signed(req_tdata[15:0]);
      cmd.frame_y = $signed(req_tdata[31:16]);
      cmd.frame_width = req_tdata[43:32];
      cmd.frame_height = req_tdata[55:44];
      case (req_tdata[57:56])
         DISP_CLEAR:   cmd.disposal = DISP_CLEAR;
         DISP_RESTORE: cmd.disposal = DISP_RESTORE;
         default:      cmd.disposal = DISP_LEAVE;
      endcase
      cmd.frame_delay = req_tdata[73:58];
      // Zero-sized frames carry no pixels, same as an explicit empty flag.
      cmd.empty = req_tdata[74] || (req_tdata[43:32] == 12'd0) ||
                  (req_tdata[55:44] == 12'd0);
      cmd.pixel_rgba = req_tdata[106:75];
      if (alpha == OPAQUE_ALPHA) begin
         cmd.alpha = ALPHA_OPAQUE;
      end else if (alpha == 8'd0) begin
         cmd.alpha = ALPHA_CLEAR;
      end else begin
         cmd.alpha = ALPHA_PARTIAL;
      end
      cmd.read_index = req_tdata[122:107];
   end

endmodule

@@ hw/rtl/afc_back.sv @@
module afc_back import afc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  cmd_type      head,
   output logic         pop,
   input  logic [8:0]   cfg_width,
   input  logic [8:0]   cfg_height,
   output logic         clearing,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata
);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [DIM_W-1:0]   live_w_ff, live_w_in, live_h_ff, live_h_in;
   logic [ADDR_W:0]    area_ff;
   logic               started_ff, started_in;
   logic [15:0]        pend_ff, pend_in;
   logic               err_ff, err_in;
   logic               recv_ff, recv_in;
   logic signed [15:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [11:0]        cur_w_ff, cur_w_in, cur_h_ff, cur_h_in;
   logic [11:0]        col_ff, col_in, row_ff, row_in;
   logic [DIM_W-1:0]   rx_ff, rx_in, ry_ff, ry_in, rw_ff, rw_in, rh_ff, rh_in;
   disp_type           ldisp_ff, ldisp_in;
   logic [DIM_W-1:0]   nx_ff, nx_in, ny_ff, ny_in, nw_ff, nw_in, nh_ff, nh_in;
   disp_type           ndisp_ff, ndisp_in;
   logic [DIM_W-1:0]   wc_ff, wc_in, wr_ff, wr_in;
   logic [ADDR_W-1:0]  sidx_ff, sidx_in;
   wb_type             wb_ff, wb_in;
   logic               oob_ff, oob_in;
   logic               out_v_ff, out_v_in;
   rsp_type            out_ff, out_in;

   logic               c_we, s_we;
   logic [ADDR_W-1:0]  c_waddr, c_raddr;
   logic [31:0]        c_wdata, c_rdata, s_rdata;

   logic               out_free;
   logic [DIM_W-1:0]   lw_eff, lh_eff;
   logic [15:0]        pend_base;
   logic [16:0]        pend_sum;
   logic signed [17:0] fx_end, fy_end, cx, cy;
   logic [DIM_W-1:0]   ox, oy;
   logic               inb;
   logic [ADDR_W:0]    pix_full, walk_full;
   logic [7:0]         walk_row, walk_col;
   logic               col_last, row_last;
   logic               pix_write;
   logic [12:0]        col_next, row_next;

   afc_ram #(.WIDTH(32), .DEPTH(CELLS)) u_canvas (
      .clock (clock),
      .we    (c_we),
      .waddr (c_waddr),
      .wdata (c_wdata),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

   afc_ram #(.WIDTH(32), .DEPTH(CELLS)) u_saved (
      .clock (clock),
      .we    (s_we),
      .waddr (wb_ff.saddr),
      .wdata (c_rdata),
      .raddr (sidx_ff),
      .rdata (s_rdata)
   );

   assign clearing = (state_ff == S_CLEAR);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {3'd0, out_ff.read_pixel, out_ff.is_final, out_ff.completed_delay,
                       out_ff.error_code, out_ff.status};
   assign out_free = !out_v_ff || rsp_tready;
   assign pop = (state_ff == S_IDLE) && head_valid && out_free;

   // Pixel position on the canvas.
   assign cx = $signed({{2{cur_x_ff[15]}}, cur_x_ff}) + $signed({6'd0, col_ff});
   assign cy = $signed({{2{cur_y_ff[15]}}, cur_y_ff}) + $signed({6'd0, row_ff});
   assign inb = !cx[17] && !cy[17] &&
                (cx < $signed({{(18 - DIM_W){1'b0}}, live_w_ff})) &&
                (cy < $signed({{(18 - DIM_W){1'b0}}, live_h_ff}));
   assign pix_full = (ADDR_W + 1)'({{(ADDR_W + 1 - 8){1'b0}}, cy[7:0]} *
                                   {{(ADDR_W + 1 - DIM_W){1'b0}}, live_w_ff}) +
                     (ADDR_W + 1)'(cx[7:0]);
   assign col_next = {1'b0, col_ff} + 13'd1;
   assign row_next = {1'b0, row_ff} + 13'd1;

   // Walk over the saved rectangle, one cell per cycle.
   assign walk_row = 8'(ry_ff + wr_ff);
   assign walk_col = 8'(rx_ff + wc_ff);
   assign walk_full = (ADDR_W + 1)'({{(ADDR_W + 1 - 8){1'b0}}, walk_row} *
                                    {{(ADDR_W + 1 - DIM_W){1'b0}}, live_w_ff}) +
                      (ADDR_W + 1)'(walk_col);
   assign col_last = (DIM_W'(wc_ff + 1'b1) == rw_ff);
   assign row_last = (DIM_W'(wr_ff + 1'b1) == rh_ff);

   // Header clipping, against the size latched by this header if it is the first.
   assign lw_eff = started_ff ? live_w_ff : clamp_dim(cfg_width, DIM_W'(MAX_W));
   assign lh_eff = started_ff ? live_h_ff : clamp_dim(cfg_height, DIM_W'(MAX_H));
   assign fx_end = $signed({{2{head.frame_x[15]}}, head.frame_x}) +
                   $signed({6'd0, head.frame_width});
   assign fy_end = $signed({{2{head.frame_y[15]}}, head.frame_y}) +
                   $signed({6'd0, head.frame_height});
   assign ox = clip_pos($signed({{2{head.frame_x[15]}}, head.frame_x}), lw_eff);
   assign oy = clip_pos($signed({{2{head.frame_y[15]}}, head.frame_y}), lh_eff);
   assign pend_base = started_ff ? pend_ff : 16'd0;
   assign pend_sum = {1'b0, pend_base} + {1'b0, head.frame_delay};

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      live_w_in = live_w_ff;
      live_h_in = live_h_ff;
      started_in = started_ff;
      pend_in = pend_ff;
      err_in = err_ff;
      recv_in = recv_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      cur_w_in = cur_w_ff;
      cur_h_in = cur_h_ff;
      col_in = col_ff;
      row_in = row_ff;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rw_in = rw_ff;
      rh_in = rh_ff;
      ldisp_in = ldisp_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      nw_in = nw_ff;
      nh_in = nh_ff;
      ndisp_in = ndisp_ff;
      wc_in = wc_ff;
      wr_in = wr_ff;
      sidx_in = sidx_ff;
      wb_in = wb_ff;
      wb_in.valid = 1'b0;
      oob_in = oob_ff;
      out_v_in = out_v_ff && !rsp_tready;
      out_in = out_ff;
      pix_write = 1'b0;
      c_raddr = head.read_index;

      case (state_ff)
         S_CLEAR: begin
            clr_in = ADDR_W'(clr_ff + 1'b1);
            if (clr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pop) begin
               out_v_in = 1'b1;
               out_in = '{status: STAT_ACCEPTED, error_code: ERR_NONE,
                          completed_delay: 16'd0, is_final: 1'b0, read_pixel: 32'd0};
               if (head.kind == KIND_READ) begin
                  // The result waits in S_READ for the registered canvas read.
                  out_v_in = 1'b0;
                  oob_in = !({1'b0, head.read_index} < area_ff);
                  state_in = S_READ;
               end else if (err_ff) begin
                  out_in.status = STAT_ERROR;
                  out_in.error_code = ERR_PARTIAL;
               end else begin
                  case (head.kind)
                     KIND_HEADER: begin
                        if (started_ff) begin
                           out_in.status = STAT_COMPLETED;
                           out_in.completed_delay = pend_ff;
                        end else begin
                           live_w_in = lw_eff;
                           live_h_in = lh_eff;
                           started_in = 1'b1;
                        end
                        recv_in = 1'b0;
                        if (head.empty) begin
                           pend_in = pend_sum[16] ? DELAY_MAX : pend_sum[15:0];
                        end else begin
                           nx_in = ox;
                           ny_in = oy;
                           nw_in = DIM_W'(clip_pos(fx_end, lw_eff) - ox);
                           nh_in = DIM_W'(clip_pos(fy_end, lh_eff) - oy);
                           ndisp_in = head.disposal;
                           cur_x_in = head.frame_x;
                           cur_y_in = head.frame_y;
                           cur_w_in = head.frame_width;
                           cur_h_in = head.frame_height;
                           col_in = 12'd0;
                           row_in = 12'd0;
                           recv_in = 1'b1;
                           pend_in = head.frame_delay;
                           wc_in = '0;
                           wr_in = '0;
                           sidx_in = '0;
                           if ((ldisp_ff == DISP_CLEAR || ldisp_ff == DISP_RESTORE) &&
                               rw_ff != '0 && rh_ff != '0) begin
                              state_in = S_DISPOSE;
                           end else begin
                              state_in = S_COMMIT;
                           end
                        end
                     end
                     KIND_PIXEL: begin
                        if (recv_ff) begin
                           if (inb && head.alpha == ALPHA_PARTIAL) begin
                              err_in = 1'b1;
                              out_in.status = STAT_ERROR;
                              out_in.error_code = ERR_PARTIAL;
                           end else begin
                              pix_write = inb && (head.alpha == ALPHA_OPAQUE);
                              if (col_next >= {1'b0, cur_w_ff}) begin
                                 col_in = 12'd0;
                                 row_in = row_next[11:0];
                                 if (row_next >= {1'b0, cur_h_ff}) begin
                                    recv_in = 1'b0;
                                 end
                              end else begin
                                 col_in = col_next[11:0];
                              end
                           end
                        end
                     end
                     KIND_FINAL: begin
                        if (started_ff) begin
                           out_in.status = STAT_COMPLETED;
                           out_in.completed_delay = pend_ff;
                           out_in.is_final = 1'b1;
                        end else begin
                           out_in.status = STAT_ERROR;
                           out_in.error_code = ERR_NO_FRAMES;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         S_READ: begin
            out_v_in = 1'b1;
            out_in = '{status: STAT_READ, error_code: ERR_NONE, completed_delay: 16'd0,
                       is_final: 1'b0, read_pixel: oob_ff ? 32'd0 : c_rdata};
            state_in = S_IDLE;
         end
         S_DISPOSE: begin
            // The saved cell comes out on the next cycle and is written back then.
            wb_in.valid = 1'b1;
            wb_in.to_canvas = 1'b1;
            wb_in.caddr = walk_full[ADDR_W-1:0];
            sidx_in = ADDR_W'(sidx_ff + 1'b1);
            if (col_last) begin
               wc_in = '0;
               wr_in = DIM_W'(wr_ff + 1'b1);
               if (row_last) begin
                  state_in = S_COMMIT;
               end
            end else begin
               wc_in = DIM_W'(wc_ff + 1'b1);
            end
         end
         S_COMMIT: begin
            rx_in = nx_ff;
            ry_in = ny_ff;
            rw_in = nw_ff;
            rh_in = nh_ff;
            ldisp_in = ndisp_ff;
            wc_in = '0;
            wr_in = '0;
            sidx_in = '0;
            if (ndisp_ff == DISP_RESTORE && nw_ff != '0 && nh_ff != '0) begin
               state_in = S_SAVE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SAVE: begin
            c_raddr = walk_full[ADDR_W-1:0];
            wb_in.valid = 1'b1;
            wb_in.to_canvas = 1'b0;
            wb_in.saddr = sidx_ff;
            sidx_in = ADDR_W'(sidx_ff + 1'b1);
            if (col_last) begin
               wc_in = '0;
               wr_in = DIM_W'(wr_ff + 1'b1);
               if (row_last) begin
                  state_in = S_IDLE;
               end
            end else begin
               wc_in = DIM_W'(wc_ff + 1'b1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      c_we = 1'b0;
      c_waddr = wb_ff.caddr;
      c_wdata = (ldisp_ff == DISP_RESTORE) ? s_rdata : BACKGROUND;
      if (state_ff == S_CLEAR) begin
         c_we = 1'b1;
         c_waddr = clr_ff;
         c_wdata = BACKGROUND;
      end else if (wb_ff.valid && wb_ff.to_canvas) begin
         c_we = 1'b1;
      end else if (pix_write) begin
         c_we = 1'b1;
         c_waddr = pix_full[ADDR_W-1:0];
         c_wdata = head.pixel_rgba;
      end
      s_we = wb_ff.valid && !wb_ff.to_canvas;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         live_w_ff <= DIM_W'(MAX_W);
         live_h_ff <= DIM_W'(MAX_H);
         started_ff <= 1'b0;
         pend_ff <= 16'd0;
         err_ff <= 1'b0;
         recv_ff <= 1'b0;
         col_ff <= 12'd0;
         row_ff <= 12'd0;
         rx_ff <= '0;
         ry_ff <= '0;
         rw_ff <= '0;
         rh_ff <= '0;
         ldisp_ff <= DISP_LEAVE;
         wb_ff.valid <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         live_w_ff <= live_w_in;
         live_h_ff <= live_h_in;
         started_ff <= started_in;
         pend_ff <= pend_in;
         err_ff <= err_in;
         recv_ff <= recv_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         rw_ff <= rw_in;
         rh_ff <= rh_in;
         ldisp_ff <= ldisp_in;
         wb_ff <= wb_in;
         out_v_ff <= out_v_in;
      end
   end

   // The area follows the size that the current item latches, so a read right
   // after the first header already sees it.
   always_ff @(posedge clock) begin
      area_ff <= (ADDR_W + 1)'({{(ADDR_W + 1 - DIM_W){1'b0}}, live_w_in} *
                               {{(ADDR_W + 1 - DIM_W){1'b0}}, live_h_in});
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      cur_w_ff <= cur_w_in;
      cur_h_ff <= cur_h_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      nw_ff <= nw_in;
      nh_ff <= nh_in;
      ndisp_ff <= ndisp_in;
      wc_ff <= wc_in;
      wr_ff <= wr_in;
      sidx_ff <= sidx_in;
      oob_ff <= oob_in;
      out_ff <= out_in;
   end

`ifndef SYNTH
   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !pop)
      else $error("item taken during the canvas clearing pass");

   a_canvas_wb_from_dispose: assert property (@(posedge clock) disable iff (reset)
      wb_ff.valid && wb_ff.to_canvas |-> $past(state_ff == S_DISPOSE))
      else $error("canvas write-back without a disposal walk");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      err_ff |=> err_ff)
      else $error("error flag cleared without reset");

   a_live_size_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> live_w_ff != '0 && live_w_ff <= DIM_W'(MAX_W) &&
                     live_h_ff != '0 && live_h_ff <= DIM_W'(MAX_H))
      else $error("latched canvas size out of range");
`endif

endmodule

@@ hw/rtl/animation_frame_compositor.sv @@
// Animation frame compositor: rebuilds full frames from partial, offset frames on an
// RGBA canvas of up to 256 by 256 pixels held in a single-port-write memory. After
// reset the canvas is cleared in one pass over all cells, during which no item is
// taken (register writes still are). Pixel, finalize and empty-header items finish in
// the idle state; a canvas read also passes the read state for the registered memory
// read. A header with pixels passes the commit state, after a walk over each cell of
// the previous frame's region when that frame asked for clear or restore, and before
// a walk over each cell of the new clipped region if the new frame asks for restore;
// these walks go through the canvas and save memories one cell a cycle. A short queue
// sits in front of the executing side and keeps taking items while a result waits; the
// executing side starts the next item once the waiting result is taken.
module animation_frame_compositor import afc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // frame_x, frame_y, frame_width, frame_height, disposal, frame_delay,
   // frame_empty, pixel_rgba, read_index
   input  logic [127:0] req_tdata,
   // opcode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, error_code, completed_delay, is_final, read_pixel
   output logic [55:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [8:0] width_ff, width_in, height_ff, height_in;
   logic       clearing, queue_full, push, pop, head_valid;
   cmd_type    cmd, head;

   assign csr_pready = 1'b1;

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_WIDTH:  width_in = csr_pwdata[8:0];
            REG_HEIGHT: height_in = csr_pwdata[8:0];
            default: begin
            end
         endcase
      end
      case (csr_paddr[2])
         REG_WIDTH:  csr_prdata = {23'd0, width_ff};
         REG_HEIGHT: csr_prdata = {23'd0, height_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

   afc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .queue_full (queue_full),
      .push       (push),
      .cmd        (cmd)
   );

   afc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   afc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ bench/animation_frame_compositor_tb.sv @@
`timescale 1ns / 1ps

module animation_frame_compositor_tb;
   import afc_pkg::*;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int SETTLE_CYCLES = 1000;
   localparam int RANDOM_ITEMS = 900;

   typedef struct {
      kind_type           op;
      logic signed [15:0] fx;
      logic signed [15:0] fy;
      logic [11:0]        fw;
      logic [11:0]        fh;
      logic [1:0]         disp;
      logic [15:0]        delay;
      logic               empty;
      logic [31:0]        rgba;
      logic [15:0]        ridx;
   } frame_item_type;

   typedef struct {
      status_type  status;
      err_type     err;
      logic [15:0] delay;
      logic        fin;
      logic [31:0] pix;
   } frame_result_type;

   class compositor_scoreboard;
      logic [31:0]      canvas[CELLS];
      logic [31:0]      saved[CELLS];
      int unsigned      save_x, save_y, save_w, save_h, last_disp;
      int unsigned      started, pend_delay, col, row, sticky_err;
      int unsigned      reg_w, reg_h, live_w, live_h, cur_w, cur_h, receiving;
      int               cur_x, cur_y;
      frame_result_type expected_q[$];
      int               failures;

      function new();
         foreach (canvas[i]) canvas[i] = '0;
         reg_w = 256;
         reg_h = 256;
         live_w = 256;
         live_h = 256;
      endfunction

      function void write_reg(int unsigned idx, logic [8:0] value);
         if (idx == REG_WIDTH) reg_w = value;
         else reg_h = value;
      endfunction

      function int unsigned fit_dim(int unsigned v);
         if (v == 0) return 1;
         return v > 256 ? 256 : v;
      endfunction

      function int clip_to(int v, int hi);
         if (v < 0) return 0;
         return v > hi ? hi : v;
      endfunction

      function void start_frame(frame_item_type it, ref frame_result_type r);
         int ox, oy, ow, oh;
         int unsigned idx;
         if (started != 0) begin
            r.status = STAT_COMPLETED;
            r.delay = pend_delay;
         end else begin
            live_w = fit_dim(reg_w);
            live_h = fit_dim(reg_h);
            foreach (canvas[i]) canvas[i] = '0;
            started = 1;
            pend_delay = 0;
         end
         receiving = 0;
         if (it.empty || it.fw == 0 || it.fh == 0) begin
            pend_delay += it.delay;
            if (pend_delay > 65535) pend_delay = 65535;
            return;
         end
         // Undo the previous frame's region before drawing the new one.
         for (int unsigned rr = 0; rr < save_h; rr++) begin
            for (int unsigned cc = 0; cc < save_w; cc++) begin
               idx = (save_y + rr) * live_w + save_x + cc;
               if (idx < CELLS && rr * save_w + cc < CELLS) begin
                  if (last_disp == DISP_CLEAR) canvas[idx] = '0;
                  else if (last_disp == DISP_RESTORE) canvas[idx] = saved[rr * save_w + cc];
               end
            end
         end
         ox = clip_to(it.fx, live_w);
         ow = clip_to(int'(it.fx) + int'(it.fw), live_w) - ox;
         oy = clip_to(it.fy, live_h);
         oh = clip_to(int'(it.fy) + int'(it.fh), live_h) - oy;
         if (ow < 0) ow = 0;
         if (oh < 0) oh = 0;
         if (it.disp == DISP_RESTORE) begin
            for (int rr = 0; rr < oh; rr++) begin
               for (int cc = 0; cc < ow; cc++) begin
                  idx = (oy + rr) * live_w + ox + cc;
                  if (idx < CELLS) saved[rr * ow + cc] = canvas[idx];
               end
            end
         end
         save_x = ox;
         save_y = oy;
         save_w = ow;
         save_h = oh;
         last_disp = it.disp;
         cur_x = it.fx;
         cur_y = it.fy;
         cur_w = it.fw;
         cur_h = it.fh;
         col = 0;
         row = 0;
         receiving = 1;
         pend_delay = it.delay;
      endfunction

      function void draw_pixel(frame_item_type it, ref frame_result_type r);
         int cx, cy;
         logic [7:0] alpha;
         alpha = it.rgba[31:24];
         if (receiving == 0) return;
         cx = cur_x + int'(col);
         cy = cur_y + int'(row);
         if (cx >= 0 && cy >= 0 && cx < int'(live_w) && cy < int'(live_h)) begin
            if (alpha == OPAQUE_ALPHA) begin
               canvas[cy * live_w + cx] = it.rgba;
            end else if (alpha != 0) begin
               sticky_err = 1;
               r.status = STAT_ERROR;
               r.err = ERR_PARTIAL;
               return;
            end
         end
         col++;
         if (col >= cur_w) begin
            col = 0;
            row++;
            if (row >= cur_h) receiving = 0;
         end
      endfunction

      function void note_item(frame_item_type it);
         frame_result_type r;
         r = '{STAT_ACCEPTED, ERR_NONE, 16'd0, 1'b0, 32'd0};
         if (it.op == KIND_READ) begin
            r.status = STAT_READ;
            if (it.ridx < live_w * live_h) r.pix = canvas[it.ridx];
         end else if (sticky_err != 0) begin
            r.status = STAT_ERROR;
            r.err = ERR_PARTIAL;
         end else if (it.op == KIND_HEADER) begin
            start_frame(it, r);
         end else if (it.op == KIND_PIXEL) begin
            draw_pixel(it, r);
         end else if (started == 0) begin
            r.status = STAT_ERROR;
            r.err = ERR_NO_FRAMES;
         end else begin
            r.status = STAT_COMPLETED;
            r.delay = pend_delay;
            r.fin = 1'b1;
         end
         expected_q.push_back(r);
      endfunction

      function void compare(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v != act_v) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(logic [55:0] data);
         frame_result_type e;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none, actual %0h", $time, data);
            return;
         end
         e = expected_q.pop_front();
         compare("status", e.status, data[1:0]);
         compare("error_code", e.err, data[3:2]);
         compare("completed_delay", e.delay, data[19:4]);
         compare("is_final", e.fin, data[20]);
         compare("read_pixel", e.pix, data[52:21]);
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [55:0]  rsp_tdata;
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [2:0]   csr_paddr;
   logic [31:0]  csr_pwdata;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   compositor_scoreboard frames;
   bit  idling_on;
   int  items_sent;
   int  cycle_count;
   int  drain_stall;

   animation_frame_compositor dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL animation_frame_compositor");
         $finish;
      end
   end

   // Result side: checks each item and stalls in random bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) frames.check_result(rsp_tdata);
      if (drain_stall > 0) begin
         drain_stall <= drain_stall - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         drain_stall <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send(frame_item_type it);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.op;
      req_tdata <= {5'd0, it.ridx, it.rgba, it.empty, it.delay, it.disp,
                    it.fh, it.fw, it.fy, it.fx};
      do @(posedge clock); while (!req_tready);
      frames.note_item(it);
      items_sent++;
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      frames.write_reg(addr >> 2, value[8:0]);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (frames.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic frame_item_type blank_item(kind_type op);
      frame_item_type it;
      it = '{op, 16'sd0, 16'sd0, 12'd0, 12'd0, 2'd0, 16'd0, 1'b0, 32'd0, 16'd0};
      it.rgba = $urandom();
      it.ridx = $urandom();
      return it;
   endfunction

   task automatic send_header(int x, int y, int w, int h, int disp, int delay, bit empty);
      frame_item_type it;
      it = blank_item(KIND_HEADER);
      it.fx = x;
      it.fy = y;
      it.fw = w;
      it.fh = h;
      it.disp = disp;
      it.delay = delay;
      it.empty = empty;
      send(it);
   endtask

   task automatic send_pixel(logic [7:0] alpha);
      frame_item_type it;
      it = blank_item(KIND_PIXEL);
      it.rgba[31:24] = alpha;
      send(it);
   endtask

   task automatic send_simple(kind_type op, logic [15:0] idx);
      frame_item_type it;
      it = blank_item(op);
      it.ridx = idx;
      send(it);
   endtask

   // One well-formed frame with random content; sometimes short, long or oversized.
   task automatic random_frame();
      int w, h, n;
      if ($urandom_range(0, 19) == 0) begin
         send_header($urandom(), $urandom(), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 3), $urandom(),
                     $urandom_range(0, 1));
         n = $urandom_range(0, 6);
      end else begin
         w = $urandom_range(0, 8);
         h = $urandom_range(0, 8);
         send_header(int'($urandom_range(0, 27)) - 5, int'($urandom_range(0, 20)) - 5,
                     w, h, $urandom_range(0, 3),
                     $urandom_range(0, 3) == 0 ? $urandom_range(60000, 65535) : $urandom(),
                     $urandom_range(0, 9) == 0);
         n = w * h;
         if ($urandom_range(0, 7) == 0) n = n + int'($urandom_range(0, 4)) - 2;
      end
      for (int i = 0; i < n; i++) begin
         send_pixel($urandom_range(0, 4) < 3 ? OPAQUE_ALPHA : 8'h00);
         if ($urandom_range(0, 9) == 0)
            send_simple(KIND_READ, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 270));
      end
      if ($urandom_range(0, 9) == 0) send_simple(KIND_FINAL, 0);
   endtask

   initial begin
      frames = new();
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= KIND_HEADER;
      rsp_tready <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      cycle_count <= 0;
      drain_stall <= 0;
      idling_on = 1'b1;
      items_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The size is latched by the first header; later writes must not change it.
      write_csr(3'd0, 32'd20);
      write_csr(3'd4, 32'd13);

      send_simple(KIND_READ, 16'd0);
      send_simple(KIND_FINAL, 16'd0);
      send_pixel(OPAQUE_ALPHA);
      send_header(-1, -1, 3, 2, DISP_RESTORE, 65535, 1'b0);
      for (int i = 0; i < 6; i++) send_pixel(i % 3 == 0 ? 8'h00 : OPAQUE_ALPHA);
      send_pixel(8'h7F);
      send_header(18, 11, 4, 4, DISP_CLEAR, 10, 1'b0);
      for (int i = 0; i < 5; i++) send_pixel(OPAQUE_ALPHA);
      send_header(2, 2, 5, 5, DISP_LEAVE, 65000, 1'b1);
      send_header(0, 0, 3, 3, DISP_LEAVE, 1000, 1'b1);
      send_header(-32768, 32767, 4095, 4095, 3, 0, 1'b0);
      send_header(32767, -32768, 0, 7, DISP_RESTORE, 5, 1'b0);
      send_simple(KIND_FINAL, 16'd0);
      send_simple(KIND_FINAL, 16'd0);
      send_simple(KIND_READ, 16'd259);
      send_simple(KIND_READ, 16'd260);
      send_simple(KIND_READ, 16'hFFFF);

      wait_idle();
      write_csr(3'd0, 32'd0);
      write_csr(3'd4, 32'd511);
      while (items_sent < RANDOM_ITEMS / 2) random_frame();
      wait_idle();
      write_csr(3'd0, 32'd256);
      write_csr(3'd4, 32'd1);
      while (items_sent < RANDOM_ITEMS - 100) random_frame();

      idling_on = 1'b0;
      while (items_sent < RANDOM_ITEMS) random_frame();
      // A partly transparent pixel inside the canvas locks the error state.
      send_header(0, 0, 2, 2, DISP_LEAVE, 3, 1'b0);
      send_pixel(8'h80);
      send_pixel(OPAQUE_ALPHA);
      send_header(1, 1, 2, 2, DISP_CLEAR, 4, 1'b0);
      send_simple(KIND_FINAL, 16'd0);
      send_simple(KIND_READ, 16'd21);
      req_tvalid <= 1'b0;

      while (frames.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (frames.failures == 0 && frames.expected_q.size() == 0) begin
         $display("PASS animation_frame_compositor");
      end else begin
         $display("FAIL animation_frame_compositor");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/afc_pkg.sv
hw/rtl/afc_ram.sv
hw/rtl/afc_queue.sv
hw/rtl/afc_front.sv
hw/rtl/afc_back.sv
hw/rtl/animation_frame_compositor.sv
bench/animation_frame_compositor_tb.sv
